// ----- rtl/core/quaternion_product_rotate_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Quaternion product/rotate unit assertion macros
// Concurrent check wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_PRODUCT_ROTATE_UNIT_ASSERT_SVH
`define QUATERNION_PRODUCT_ROTATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// check on every clock edge out of reset
`define QPROT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qprot check failed");
// check on every clock edge, reset included
`define QPROT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("qprot check failed");
`else
`define QPROT_ASSERT(lbl, clk, rst_n, prop)
`define QPROT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/core/qprot_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion product/rotate unit package
// Default component format and the operation select codes.
// ----------------------------------------------------------------------------
package qprot_pkg;

    // default component format: Q1.14 in 16 bits
    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    typedef logic [1:0] t_func;

    localparam t_func FUNC_PROD = 2'd0;
    localparam t_func FUNC_ROT  = 2'd1;
    localparam t_func FUNC_NORM = 2'd2;
    localparam t_func FUNC_CONJ = 2'd3;

endpackage
`default_nettype wire

// ----- rtl/core/quaternion_product_rotate_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion product and rotate unit
// Hamilton product, vector rotation, normalization and conjugate on signed
// fixed-point quaternions, fully pipelined.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock while the output is not stalled and
// returns one result per item in order. Every item, whatever its operation,
// passes the same stages from input transfer to output valid: five stages
// hold the two multiply/round rounds of the product and rotation, then an
// integer square root resolves one root bit per stage (COMP_WIDTH+1 stages)
// and four parallel restoring dividers resolve one quotient bit per stage
// (COMP_WIDTH+FRAC_BITS+1 stages) for normalization, between a divider setup
// register and the output register. A stalled output holds the whole pipeline;
// s_tready is low only while the output register is full and not taken.
`include "quaternion_product_rotate_unit_assert.svh"

module quaternion_product_rotate_unit #(
    parameter int COMP_WIDTH = qprot_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qprot_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w from bit 0 up
    input  wire logic [8*COMP_WIDTH-1:0]              i_s_tdata,
    // func
    input  wire qprot_pkg::t_func                     i_s_tuser,
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    // r_x, r_y, r_z, r_w from bit 0 up, zero filled to whole bytes
    output logic [((4*COMP_WIDTH+7)/8)*8-1:0]         o_m_tdata,
    // overflow, zero_norm from bit 0 up
    output logic [1:0]                                o_m_tuser
);
    import qprot_pkg::*;

    localparam int CW   = COMP_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int PW   = 2*CW;
    localparam int SW   = 2*CW+4;
    localparam int SSW  = 2*CW+2;
    localparam int NQ   = CW+1;
    localparam int RW   = CW+4;
    localparam int MW   = CW+1;
    localparam int NW   = CW+FB+1;
    localparam int ND   = NW;
    localparam int DW   = CW+2;
    localparam int ODW  = ((4*CW+7)/8)*8;
    localparam int CARW = 8*CW+8;
    // carry bundle layout
    localparam int C_SGN = 4*CW;
    localparam int C_FN  = 4*CW+4;
    localparam int C_ZN  = 4*CW+6;
    localparam int C_OV  = 4*CW+7;
    localparam int C_RS  = 4*CW+8;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [SW-1:0] SMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic signed [SW-1:0] HALF = {{(SW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
    localparam logic [NW-1:0] QMAX_POS = {{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [NW-1:0] QMAX_NEG = {{(NW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

    // round half up by FB fraction bits, then saturate; top bit flags saturation
    function automatic logic [CW:0] rnd_sat(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] v;
        v = (s + HALF) >>> FB;
        if (v > SMAX) begin
            rnd_sat = {1'b1, CMAX};
        end else if (v < SMIN) begin
            rnd_sat = {1'b1, CMIN};
        end else begin
            rnd_sat = {1'b0, v[CW-1:0]};
        end
    endfunction

    logic w_en;

    // global advance: hold everything while the output waits
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // ------------------------------------------------------------------
    // stage 0: input register
    // ------------------------------------------------------------------
    logic                 r0_vld;
    t_func                r0_func;
    logic signed [CW-1:0] r0_a [4];
    logic signed [CW-1:0] r0_b [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_func <= i_s_tuser;
            for (int i = 0; i < 4; i++) begin
                r0_a[i] <= i_s_tdata[i*CW +: CW];
                r0_b[i] <= i_s_tdata[(4+i)*CW +: CW];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: all a*b products, squares and magnitudes
    // ------------------------------------------------------------------
    logic signed [CW-1:0] n1_b [4];
    logic                 r1_vld;
    t_func                r1_func;
    logic signed [CW-1:0] r1_a [4];
    logic signed [PW-1:0] r1_p [4][4];
    logic [PW-1:0]        r1_sq [4];
    logic [CW-1:0]        r1_mag [4];

    // rotation treats b as a pure vector
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n1_b[j] = (r0_func == FUNC_ROT && j == 3) ? '0 : r0_b[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_func <= r0_func;
            for (int i = 0; i < 4; i++) begin
                r1_a[i]   <= r0_a[i];
                r1_sq[i]  <= PW'(r0_a[i]) * PW'(r0_a[i]);
                r1_mag[i] <= r0_a[i][CW-1] ? CW'(-r0_a[i]) : CW'(r0_a[i]);
                for (int j = 0; j < 4; j++) begin
                    r1_p[i][j] <= PW'(r0_a[i]) * PW'(n1_b[j]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: first Hamilton sums, rounding; sum of squares
    // ------------------------------------------------------------------
    logic signed [SW-1:0] n2_sum [4];
    logic [CW:0]          n2_rs [4];
    logic [SSW-1:0]       n2_s;
    logic                 r2_vld;
    t_func                r2_func;
    logic signed [CW-1:0] r2_a [4];
    logic signed [CW-1:0] r2_t [4];
    logic                 r2_ovf;
    logic                 r2_zn;
    logic [SSW-1:0]       r2_s;
    logic [CW-1:0]        r2_mag [4];

    always_comb begin
        n2_sum[0] = SW'(r1_p[3][0]) + SW'(r1_p[0][3]) + SW'(r1_p[1][2]) - SW'(r1_p[2][1]);
        n2_sum[1] = SW'(r1_p[3][1]) + SW'(r1_p[1][3]) + SW'(r1_p[2][0]) - SW'(r1_p[0][2]);
        n2_sum[2] = SW'(r1_p[3][2]) + SW'(r1_p[2][3]) + SW'(r1_p[0][1]) - SW'(r1_p[1][0]);
        n2_sum[3] = SW'(r1_p[3][3]) - SW'(r1_p[0][0]) - SW'(r1_p[1][1]) - SW'(r1_p[2][2]);
        for (int i = 0; i < 4; i++) begin
            n2_rs[i] = rnd_sat(n2_sum[i]);
        end
        n2_s = SSW'(r1_sq[0]) + SSW'(r1_sq[1]) + SSW'(r1_sq[2]) + SSW'(r1_sq[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_func <= r1_func;
            r2_ovf  <= n2_rs[0][CW] | n2_rs[1][CW] | n2_rs[2][CW] | n2_rs[3][CW];
            r2_zn   <= (n2_s == '0);
            r2_s    <= n2_s;
            for (int i = 0; i < 4; i++) begin
                r2_a[i]   <= r1_a[i];
                r2_t[i]   <= n2_rs[i][CW-1:0];
                r2_mag[i] <= r1_mag[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: products of t with conj(a)
    // ------------------------------------------------------------------
    logic signed [CW:0]   n3_c [4];
    logic                 r3_vld;
    t_func                r3_func;
    logic signed [CW-1:0] r3_a [4];
    logic signed [CW-1:0] r3_t [4];
    logic signed [PW:0]   r3_q [4][4];
    logic                 r3_ovf;
    logic                 r3_zn;
    logic [SSW-1:0]       r3_s;
    logic [CW-1:0]        r3_mag [4];

    // conjugate taken exactly, one bit wider
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n3_c[j] = (j == 3) ? (CW+1)'(r2_a[j]) : -(CW+1)'(r2_a[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_func <= r2_func;
            r3_ovf  <= r2_ovf;
            r3_zn   <= r2_zn;
            r3_s    <= r2_s;
            for (int i = 0; i < 4; i++) begin
                r3_a[i]   <= r2_a[i];
                r3_t[i]   <= r2_t[i];
                r3_mag[i] <= r2_mag[i];
                for (int j = 0; j < 4; j++) begin
                    r3_q[i][j] <= (PW+1)'(r2_t[i]) * (PW+1)'(n3_c[j]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: second sums, early results, square root setup
    // ------------------------------------------------------------------
    logic signed [SW-1:0] n4_sum [3];
    logic [CW:0]          n4_rs [3];
    logic [4*CW-1:0]      n4_res;
    logic                 n4_ovf;
    logic [CARW-1:0]      n4_car;

    always_comb begin
        n4_sum[0] = SW'(r3_q[3][0]) + SW'(r3_q[0][3]) + SW'(r3_q[1][2]) - SW'(r3_q[2][1]);
        n4_sum[1] = SW'(r3_q[3][1]) + SW'(r3_q[1][3]) + SW'(r3_q[2][0]) - SW'(r3_q[0][2]);
        n4_sum[2] = SW'(r3_q[3][2]) + SW'(r3_q[2][3]) + SW'(r3_q[0][1]) - SW'(r3_q[1][0]);
        for (int i = 0; i < 3; i++) begin
            n4_rs[i] = rnd_sat(n4_sum[i]);
        end
        n4_res = '0;
        n4_ovf = 1'b0;
        unique case (r3_func)
            FUNC_PROD: begin
                n4_res = {r3_t[3], r3_t[2], r3_t[1], r3_t[0]};
                n4_ovf = r3_ovf;
            end
            FUNC_ROT: begin
                n4_res = {{CW{1'b0}}, n4_rs[2][CW-1:0], n4_rs[1][CW-1:0], n4_rs[0][CW-1:0]};
                n4_ovf = r3_ovf | n4_rs[0][CW] | n4_rs[1][CW] | n4_rs[2][CW];
            end
            FUNC_NORM: begin
                n4_res = '0;
                n4_ovf = 1'b0;
            end
            FUNC_CONJ: begin
                n4_res[3*CW +: CW] = r3_a[3];
                for (int i = 0; i < 3; i++) begin
                    if (r3_a[i] == CMIN) begin
                        n4_res[i*CW +: CW] = CMAX;
                        n4_ovf = 1'b1;
                    end else begin
                        n4_res[i*CW +: CW] = -r3_a[i];
                    end
                end
            end
            default: begin
                n4_res = '0;
                n4_ovf = 1'b0;
            end
        endcase
        n4_car = {n4_res, n4_ovf, r3_zn, r3_func,
                  r3_a[3][CW-1], r3_a[2][CW-1], r3_a[1][CW-1], r3_a[0][CW-1],
                  r3_mag[3], r3_mag[2], r3_mag[1], r3_mag[0]};
    end

    // square root chain, index 0 is the stage 4 register
    logic            r_sq_vld  [0:NQ];
    logic [CARW-1:0] r_sq_car  [0:NQ];
    logic [RW-1:0]   r_sq_rem  [0:NQ];
    logic [MW-1:0]   r_sq_root [0:NQ];
    logic [SSW-1:0]  r_sq_s    [0:NQ];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_vld[0] <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_car[0]  <= n4_car;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_s[0]    <= r3_s;
        end
    end

    // ------------------------------------------------------------------
    // square root: one root bit per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NQ; k++) begin : g_sqrt
        logic [RW-1:0] n_rem;
        logic [RW-1:0] n_trial;
        logic          n_geq;

        always_comb begin
            n_rem   = {r_sq_rem[k][RW-3:0], r_sq_s[k][SSW-1 -: 2]};
            n_trial = RW'({r_sq_root[k], 2'b01});
            n_geq   = (n_rem >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_car[k+1]  <= r_sq_car[k];
                r_sq_rem[k+1]  <= n_geq ? (n_rem - n_trial) : n_rem;
                r_sq_root[k+1] <= {r_sq_root[k][MW-2:0], n_geq};
                r_sq_s[k+1]    <= {r_sq_s[k][SSW-3:0], 2'b00};
            end
        end
    end

    // ------------------------------------------------------------------
    // divider setup: numerator = |a_i| << FB plus half the magnitude
    // ------------------------------------------------------------------
    logic            r_dv_vld [0:ND];
    logic [CARW-1:0] r_dv_car [0:ND];
    logic [MW-1:0]   r_dv_m   [0:ND];
    logic [NW-1:0]   r_dv_num [0:ND][4];
    logic [DW-1:0]   r_dv_rem [0:ND][4];
    logic [NW-1:0]   r_dv_q   [0:ND][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_vld[0] <= r_sq_vld[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_car[0] <= r_sq_car[NQ];
            r_dv_m[0]   <= r_sq_root[NQ];
            for (int i = 0; i < 4; i++) begin
                r_dv_num[0][i] <= NW'({r_sq_car[NQ][i*CW +: CW], {FB{1'b0}}})
                                + NW'(r_sq_root[NQ] >> 1);
                r_dv_rem[0][i] <= '0;
                r_dv_q[0][i]   <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // four restoring dividers: one quotient bit per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < ND; k++) begin : g_div
        logic [DW-1:0] n_rsh [4];
        logic          n_geq [4];

        always_comb begin
            for (int i = 0; i < 4; i++) begin
                n_rsh[i] = {r_dv_rem[k][i][DW-2:0], r_dv_num[k][i][NW-1]};
                n_geq[i] = (n_rsh[i] >= DW'(r_dv_m[k]));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_car[k+1] <= r_dv_car[k];
                r_dv_m[k+1]   <= r_dv_m[k];
                for (int i = 0; i < 4; i++) begin
                    r_dv_num[k+1][i] <= {r_dv_num[k][i][NW-2:0], 1'b0};
                    r_dv_rem[k+1][i] <= n_geq[i] ? (n_rsh[i] - DW'(r_dv_m[k])) : n_rsh[i];
                    r_dv_q[k+1][i]   <= {r_dv_q[k][i][NW-2:0], n_geq[i]};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output stage: sign and saturate quotients, select result
    // ------------------------------------------------------------------
    logic [CARW-1:0]      n_car;
    logic [NW-1:0]        n_neg [4];
    logic [4*CW-1:0]      n_res;
    logic                 n_ovf;
    logic                 n_zn;
    logic                 r_out_vld;
    t_func                r_out_func;
    logic [4*CW-1:0]      r_out_res;
    logic                 r_out_ovf;
    logic                 r_out_zn;

    always_comb begin
        n_car = r_dv_car[ND];
        n_res = n_car[C_RS +: 4*CW];
        n_ovf = n_car[C_OV];
        n_zn  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            n_neg[i] = -r_dv_q[ND][i];
        end
        if (n_car[C_FN +: 2] == FUNC_NORM) begin
            n_res = '0;
            n_ovf = 1'b0;
            if (n_car[C_ZN]) begin
                n_zn = 1'b1;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    if (!n_car[C_SGN+i]) begin
                        if (r_dv_q[ND][i] > QMAX_POS) begin
                            n_res[i*CW +: CW] = CMAX;
                            n_ovf = 1'b1;
                        end else begin
                            n_res[i*CW +: CW] = r_dv_q[ND][i][CW-1:0];
                        end
                    end else begin
                        if (r_dv_q[ND][i] > QMAX_NEG) begin
                            n_res[i*CW +: CW] = CMIN;
                            n_ovf = 1'b1;
                        end else begin
                            n_res[i*CW +: CW] = n_neg[i][CW-1:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dv_vld[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_func <= n_car[C_FN +: 2];
            r_out_res  <= n_res;
            r_out_ovf  <= n_ovf;
            r_out_zn   <= n_zn;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = ODW'(r_out_res);
    assign o_m_tuser  = {r_out_zn, r_out_ovf};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `QPROT_ASSERT(a_zn_gives_zero, i_clk, i_rst_n, o_m_tvalid && r_out_zn |-> r_out_res == '0 && !r_out_ovf)
    `QPROT_ASSERT(a_zn_only_norm, i_clk, i_rst_n, o_m_tvalid && r_out_zn |-> r_out_func == FUNC_NORM)
    `QPROT_ASSERT(a_rot_w_zero, i_clk, i_rst_n, o_m_tvalid && r_out_func == FUNC_ROT |-> r_out_res[4*CW-1 -: CW] == '0)
    `QPROT_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !o_m_tvalid)

endmodule
`default_nettype wire

// ----- verif/quaternion_product_rotate_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion product/rotate unit checker
// Watches both stream channels, computes the expected result of every input
// transfer and compares each output transfer against the oldest expected one.
// ----------------------------------------------------------------------------
module quaternion_product_rotate_unit_checker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wire logic             i_s_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w from bit 0 up
    input  wire logic [127:0]     i_s_tdata,
    // func
    input  wire qprot_pkg::t_func i_s_tuser,
    input  wire logic             i_m_tvalid,
    input  wire logic             i_m_tready,
    // r_x, r_y, r_z, r_w from bit 0 up
    input  wire logic [63:0]      i_m_tdata,
    // overflow, zero_norm from bit 0 up
    input  wire logic [1:0]       i_m_tuser,
    output int                    o_errors,
    output int                    o_pending
);
    import qprot_pkg::*;

    localparam int  FRAC = FRAC_BITS_DEF;
    localparam longint CMAX = 32767;
    localparam longint CMIN = -32768;

    typedef struct {
        logic [15:0] r[4];
        logic        ovf;
        logic        zn;
    } t_quat_result;

    t_quat_result expected_results[$];

    // saturate to the component range, flag on clip
    function automatic longint sat_comp(input longint v, inout bit ovf);
        if (v > CMAX) begin
            ovf = 1'b1;
            return CMAX;
        end
        if (v < CMIN) begin
            ovf = 1'b1;
            return CMIN;
        end
        return v;
    endfunction

    // sum of products, rounded half up by the fraction bits
    function automatic longint round_prod(input longint p0, input longint p1,
                                          input longint p2, input longint p3);
        longint s;
        s = p0 + p1 + p2 + p3 + (longint'(1) <<< (FRAC - 1));
        return s >>> FRAC;
    endfunction

    function automatic longint int_root(input longint v);
        longint lo, hi, mid;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // Hamilton product with saturation of every component
    function automatic void hamilton_sat(input longint p[4], input longint q[4],
                                         output longint r[4], inout bit ovf);
        r[0] = sat_comp(round_prod(p[3]*q[0], q[3]*p[0], p[1]*q[2], -(p[2]*q[1])), ovf);
        r[1] = sat_comp(round_prod(p[3]*q[1], q[3]*p[1], p[2]*q[0], -(p[0]*q[2])), ovf);
        r[2] = sat_comp(round_prod(p[3]*q[2], q[3]*p[2], p[0]*q[1], -(p[1]*q[0])), ovf);
        r[3] = sat_comp(round_prod(p[3]*q[3], -(p[0]*q[0]), -(p[1]*q[1]), -(p[2]*q[2])),
                        ovf);
    endfunction

    function automatic t_quat_result quat_op(input t_func func, input logic [127:0] d);
        longint a[4], b[4], t[4], c[4], r[4];
        longint mag, s, m;
        bit ovf, zn;
        t_quat_result res;
        ovf = 1'b0;
        zn  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            a[i] = longint'($signed(d[16*i +: 16]));
            b[i] = longint'($signed(d[16*(i+4) +: 16]));
            r[i] = 0;
        end
        case (func)
            FUNC_PROD: hamilton_sat(a, b, r, ovf);
            FUNC_ROT: begin
                // t = a*(b,0), then vector part of t*conj(a); no scalar part formed
                b[3] = 0;
                hamilton_sat(a, b, t, ovf);
                c[0] = -a[0]; c[1] = -a[1]; c[2] = -a[2]; c[3] = a[3];
                r[0] = sat_comp(round_prod(t[3]*c[0], c[3]*t[0], t[1]*c[2], -(t[2]*c[1])),
                                ovf);
                r[1] = sat_comp(round_prod(t[3]*c[1], c[3]*t[1], t[2]*c[0], -(t[0]*c[2])),
                                ovf);
                r[2] = sat_comp(round_prod(t[3]*c[2], c[3]*t[2], t[0]*c[1], -(t[1]*c[0])),
                                ovf);
                r[3] = 0;
            end
            FUNC_NORM: begin
                s = 0;
                for (int i = 0; i < 4; i++) s += a[i] * a[i];
                if (s == 0) begin
                    zn = 1'b1;
                end else begin
                    m = int_root(s);
                    for (int i = 0; i < 4; i++) begin
                        mag = (a[i] < 0) ? -a[i] : a[i];
                        mag = ((mag <<< FRAC) + m / 2) / m;
                        r[i] = sat_comp((a[i] < 0) ? -mag : mag, ovf);
                    end
                end
            end
            default: begin
                for (int i = 0; i < 3; i++) r[i] = sat_comp(-a[i], ovf);
                r[3] = a[3];
            end
        endcase
        for (int i = 0; i < 4; i++) res.r[i] = r[i][15:0];
        res.ovf = ovf;
        res.zn  = zn;
        return res;
    endfunction

    assign o_pending = expected_results.size();

    // predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_quat_result exp_res;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(quat_op(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%b", $time,
                             i_m_tdata, i_m_tuser);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_m_tdata != {exp_res.r[3], exp_res.r[2], exp_res.r[1],
                                      exp_res.r[0]} ||
                        i_m_tuser != {exp_res.zn, exp_res.ovf}) begin
                        $display("%0t: mismatch expected r=%h/%h/%h/%h ovf=%b zn=%b",
                                 $time, exp_res.r[0], exp_res.r[1], exp_res.r[2],
                                 exp_res.r[3], exp_res.ovf, exp_res.zn);
                        $display("%0t:          actual   r=%h/%h/%h/%h ovf=%b zn=%b",
                                 $time, i_m_tdata[15:0], i_m_tdata[31:16],
                                 i_m_tdata[47:32], i_m_tdata[63:48], i_m_tuser[0],
                                 i_m_tuser[1]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- verif/quaternion_product_rotate_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion product/rotate unit testbench
// Drives directed corner items and then random items of every operation with
// random idle bursts on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module quaternion_product_rotate_unit_tb;
    import qprot_pkg::*;

    localparam int NUM_RANDOM  = 600;
    localparam int PIPE_CYCLES = 55;
    localparam int CYCLE_LIMIT = 200000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [127:0] i_s_tdata;
    t_func        i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [63:0]  o_m_tdata;
    logic [1:0]   o_m_tuser;
    int           err_count;
    int           pending_count;
    int           cycle_count;
    bit           idle_enable;

    quaternion_product_rotate_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    quaternion_product_rotate_unit_checker checker_inst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .o_errors   (err_count),
        .o_pending  (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // end the run on a hang
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one quaternion operation: hold until the transfer completes
    task automatic send_op(input t_func func, input logic [15:0] ax, input logic [15:0] ay,
                           input logic [15:0] az, input logic [15:0] aw,
                           input logic [15:0] bx, input logic [15:0] by,
                           input logic [15:0] bz, input logic [15:0] bw);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {bw, bz, by, bx, aw, az, ay, ax};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // random component: full range, within plus or minus one, small, or one of max, min, zero and one
    function automatic logic [15:0] rand_comp(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 32767) - 16384);
            2: return 16'($urandom_range(0, 16) - 8);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'h7fff;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    default: return 16'h4000;
                endcase
            end
        endcase
    endfunction

    // output side: random stall bursts
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (idle_enable && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        logic [15:0] c[8];
        int mode;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = FUNC_PROD;
        cycle_count = 0;
        idle_enable = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, unit quaternions, zero norm, conjugate of minimum
        send_op(FUNC_PROD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_op(FUNC_PROD, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_op(FUNC_PROD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_op(FUNC_PROD, 0, 0, 0, 16'h4000, 16'h1234, 16'hedcb, 16'h0100, 16'h4000);
        send_op(FUNC_PROD, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(FUNC_PROD, 16'h0001, 16'hffff, 16'h0001, 16'hffff,
                16'h2000, 16'h2000, 16'h2000, 16'h2000);
        send_op(FUNC_ROT, 0, 0, 0, 16'h4000, 16'h1000, 16'h2000, 16'h3000, 16'h7fff);
        send_op(FUNC_ROT, 0, 0, 16'h2d41, 16'h2d41, 16'h4000, 0, 0, 0);
        send_op(FUNC_ROT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
        send_op(FUNC_ROT, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_op(FUNC_ROT, 0, 0, 0, 0, 16'h1111, 16'h2222, 16'h3333, 0);
        send_op(FUNC_NORM, 0, 0, 0, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_op(FUNC_NORM, 0, 0, 0, 16'h0001, 0, 0, 0, 0);
        send_op(FUNC_NORM, 16'h8000, 0, 0, 0, 0, 0, 0, 0);
        send_op(FUNC_NORM, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 0);
        send_op(FUNC_NORM, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0);
        send_op(FUNC_NORM, 16'hffff, 16'h0001, 16'hffff, 16'h0002, 0, 0, 0, 0);
        send_op(FUNC_CONJ, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0);
        send_op(FUNC_CONJ, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_op(FUNC_CONJ, 16'h1234, 16'h8000, 16'h0000, 16'h8000, 0, 0, 0, 0);

        // random items of every operation; the last quarter runs without idling
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM * 3 / 4) idle_enable = 1'b0;
            for (int i = 0; i < 8; i++) begin
                mode = $urandom_range(0, 9);
                c[i] = rand_comp(mode < 5 ? 0 : mode < 8 ? 1 : mode < 9 ? 2 : 3);
            end
            send_op(t_func'($urandom_range(0, 3)), c[0], c[1], c[2], c[3],
                    c[4], c[5], c[6], c[7]);
        end
        i_s_tvalid <= 1'b0;

        // drain: wait for every result, then wait past the pipeline depth
        while (pending_count != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES + 5) @(posedge i_clk);
        if (err_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
